### hw/rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants for the frustum box cull block
// Opcodes, item kinds, the queue entry and the datapath widths.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned EXT_W       = 31;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned MAT_DEPTH   = 16;
  localparam int unsigned MAT_IDX_W   = $clog2(MAT_DEPTH);
  localparam int unsigned MAT_COLS    = 4;
  localparam int unsigned COL_W       = $clog2(MAT_COLS);
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned NUM_PLANES  = 6;
  localparam int unsigned PL_W        = $clog2(NUM_PLANES);
  localparam int unsigned PLANE_W     = DATA_W + 1;
  localparam int unsigned SUM_W       = DATA_W + 2;
  localparam int unsigned ACC_W       = 68;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [COL_W-1:0] ROW_W   = COL_W'(3);
  localparam logic [COL_W-1:0] COL_D   = COL_W'(3);
  localparam logic [PL_W-1:0]  PLANE_Z = PL_W'(4);

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_TEST,
    KIND_PASS
  } kind_e;

  typedef struct packed {
    kind_e                               kind;
    logic [MAT_IDX_W-1:0]                index;
    logic [DATA_W-1:0]                   value;
    logic [NUM_AXES-1:0][SUM_W-1:0]      cpe;
    logic [NUM_AXES-1:0][SUM_W-1:0]      cme;
  } cmd_t;

endpackage

### hw/rtl/frustum_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_box_cull: view-frustum culling of axis-aligned boxes
// Loads a 4x4 matrix element by element and tests boxes against six planes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | opcode, element, box fields
//  out     | output    | out_valid_o/out_ready_i | visible_o
//
//  Load beats write the matrix; an invalid box goes straight out as visible.
//  A box test is taken from the queue, then runs 18 steps on the one shared
//  multiplier (six planes, three axes each), drains the pipeline and issues
//  its result out.
//  Reset clears the matrix to zero, so every box reads as visible.
//  A two-entry queue lets the input run ahead while the engine or output stalls.
// ----------------------------------------------------------------------------
module frustum_box_cull import fbc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     opcode_i,
  input  logic [MAT_IDX_W-1:0]     element_index_i,
  input  logic signed [DATA_W-1:0] element_value_i,
  input  logic signed [DATA_W-1:0] center_x_i,
  input  logic signed [DATA_W-1:0] center_y_i,
  input  logic signed [DATA_W-1:0] center_z_i,
  input  logic [EXT_W-1:0]         extent_x_i,
  input  logic [EXT_W-1:0]         extent_y_i,
  input  logic [EXT_W-1:0]         extent_z_i,
  input  logic                     bounds_valid_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     visible_o
);

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  fbc_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .center_z_i      (center_z_i),
    .extent_x_i      (extent_x_i),
    .extent_y_i      (extent_y_i),
    .extent_z_i      (extent_z_i),
    .bounds_valid_i  (bounds_valid_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_cmd_o      (push_cmd)
  );

  fbc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  fbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_cmd_i     (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .visible_o   (visible_o)
  );

endmodule

### hw/rtl/fbc_front.sv
// ----------------------------------------------------------------------------
// fbc_front: input classifier
// Sorts each beat into load, test or pass and folds the box into c+e and c-e.
// ----------------------------------------------------------------------------
module fbc_front import fbc_pkg::*; (
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     opcode_i,
  input  logic [MAT_IDX_W-1:0]     element_index_i,
  input  logic signed [DATA_W-1:0] element_value_i,
  input  logic signed [DATA_W-1:0] center_x_i,
  input  logic signed [DATA_W-1:0] center_y_i,
  input  logic signed [DATA_W-1:0] center_z_i,
  input  logic [EXT_W-1:0]         extent_x_i,
  input  logic [EXT_W-1:0]         extent_y_i,
  input  logic [EXT_W-1:0]         extent_z_i,
  input  logic                     bounds_valid_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output cmd_t                     push_cmd_o
);

  logic signed [NUM_AXES-1:0][DATA_W-1:0] center;
  logic        [NUM_AXES-1:0][EXT_W-1:0]  extent;

  assign center = {center_z_i, center_y_i, center_x_i};
  assign extent = {extent_z_i, extent_y_i, extent_x_i};

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_cmd_o       = '0;
    push_cmd_o.index = element_index_i;
    push_cmd_o.value = element_value_i;
    priority if (opcode_i == OP_LOAD) begin
      push_cmd_o.kind = KIND_LOAD;
    end else if (!bounds_valid_i) begin
      push_cmd_o.kind = KIND_PASS;
    end else begin
      push_cmd_o.kind = KIND_TEST;
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      push_cmd_o.cpe[i] = SUM_W'($signed(center[i])) + {{(SUM_W-EXT_W){1'b0}}, extent[i]};
      push_cmd_o.cme[i] = SUM_W'($signed(center[i])) - {{(SUM_W-EXT_W){1'b0}}, extent[i]};
    end
  end

endmodule

### hw/rtl/fbc_queue.sv
// ----------------------------------------------------------------------------
// fbc_queue: command queue
// Short first-in first-out store between the classifier and the cull engine.
// ----------------------------------------------------------------------------
module fbc_queue import fbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
    else $error("queue count did not grow on push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step with count");
`endif

endmodule

### hw/rtl/fbc_back.sv
// ----------------------------------------------------------------------------
// fbc_back: cull engine
// Holds the matrix, runs each valid box through six planes on one shared multiplier.
// ----------------------------------------------------------------------------
module fbc_back import fbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_ready_o,
  input  cmd_t q_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic visible_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [DATA_W-1:0] mat_q [MAT_DEPTH];

  logic [NUM_AXES-1:0][SUM_W-1:0] cpe_q, cme_q;
  logic [PL_W-1:0]  pl_q;
  logic [COL_W-1:0] k_q;
  logic             vis_q;
  logic             out_valid_q, visible_q;

  logic                       s1_vld_q, s1_first_q, s1_last_q, s1_final_q, s1_nz_q;
  logic signed [PLANE_W-1:0]  s1_n_q, s1_d_q;
  logic signed [SUM_W-1:0]    s1_a_q;

  logic                       s2_vld_q, s2_first_q, s2_last_q, s2_final_q, s2_nz_q;
  logic signed [PLANE_W-1:0]  s2_d_q;
  logic signed [ACC_W-1:0]    s2_prod_q;

  logic signed [ACC_W-1:0]    acc_q, acc_base, acc_new;
  logic                       nz_q, nz_new;

  logic                       out_free, pop, issue, last_issue, cull, out_set;
  logic [COL_W-1:0]           row_sel;
  logic                       sub, zero_w;
  logic signed [PLANE_W-1:0]  wk, rk, wd, rd, n, d;

  assign out_free   = !out_valid_q || out_ready_i;
  assign pop        = (state_q == ST_IDLE) && q_valid_i &&
                      (q_cmd_i.kind != KIND_PASS || out_free);
  assign q_ready_o  = pop;
  assign issue      = (state_q == ST_ISSUE);
  assign last_issue = issue && (pl_q == PL_W'(NUM_PLANES - 1)) &&
                      (k_q == COL_W'(NUM_AXES - 1));
  assign out_set    = (pop && q_cmd_i.kind == KIND_PASS) ||
                      (state_q == ST_DONE && out_free);

  // form one plane component and the plane offset
  always_comb begin
    row_sel = COL_W'(pl_q >> 1);
    sub     = pl_q[0];
    zero_w  = (pl_q == PLANE_Z);
    wk      = PLANE_W'($signed(mat_q[{ROW_W, k_q}]));
    rk      = PLANE_W'($signed(mat_q[{row_sel, k_q}]));
    wd      = PLANE_W'($signed(mat_q[{ROW_W, COL_D}]));
    rd      = PLANE_W'($signed(mat_q[{row_sel, COL_D}]));
    n       = sub ? (wk - rk) : ((zero_w ? '0 : wk) + rk);
    d       = sub ? (wd - rd) : ((zero_w ? '0 : wd) + rd);
  end

  always_comb begin
    acc_base = s2_first_q ? (ACC_W'(s2_d_q) <<< FRAC_W) : acc_q;
    acc_new  = acc_base + s2_prod_q;
    nz_new   = (s2_first_q ? 1'b0 : nz_q) | s2_nz_q;
    cull     = s2_vld_q && s2_last_q && nz_new && acc_new[ACC_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pl_q        <= '0;
      k_q         <= '0;
      vis_q       <= 1'b1;
      out_valid_q <= 1'b0;
      visible_q   <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cull) begin
        vis_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            unique case (q_cmd_i.kind)
              KIND_PASS: begin
                visible_q <= 1'b1;
              end
              KIND_TEST: begin
                state_q <= ST_ISSUE;
                pl_q    <= '0;
                k_q     <= '0;
                vis_q   <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_ISSUE: begin
          if (k_q == COL_W'(NUM_AXES - 1)) begin
            k_q  <= '0;
            pl_q <= pl_q + PL_W'(1);
          end else begin
            k_q <= k_q + COL_W'(1);
          end
          if (last_issue) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (s2_vld_q && s2_final_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            visible_q <= vis_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAT_DEPTH; i++) begin
        mat_q[i] <= '0;
      end
    end else if (pop && q_cmd_i.kind == KIND_LOAD) begin
      mat_q[q_cmd_i.index] <= q_cmd_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_cmd_i.kind == KIND_TEST) begin
      cpe_q <= q_cmd_i.cpe;
      cme_q <= q_cmd_i.cme;
    end
    // stage 1: plane component, signed box term
    s1_n_q     <= n;
    s1_d_q     <= d;
    s1_a_q     <= n[PLANE_W-1] ? $signed(cme_q[k_q]) : $signed(cpe_q[k_q]);
    s1_nz_q    <= (n != '0);
    s1_first_q <= (k_q == '0);
    s1_last_q  <= (k_q == COL_W'(NUM_AXES - 1));
    s1_final_q <= last_issue;
    // stage 2: product
    s2_prod_q  <= ACC_W'(s1_n_q) * ACC_W'(s1_a_q);
    s2_d_q     <= s1_d_q;
    s2_nz_q    <= s1_nz_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_final_q <= s1_final_q;
    // stage 3: accumulate
    if (s2_vld_q) begin
      acc_q <= acc_new;
      nz_q  <= nz_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

`ifndef SYNTHESIS
  a_pipe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q || s2_vld_q) |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
    else $error("plane pipeline active outside a box test");
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_final_q) |-> s2_last_q)
    else $error("final step is not the last axis of a plane");
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_o && state_q == ST_IDLE))
    else $error("finished box produced no result");
  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> (pl_q < PL_W'(NUM_PLANES)))
    else $error("plane counter out of range");
`endif

endmodule

### bench/frustum_box_cull_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_box_cull_test: self-checking bench for the frustum box cull block
// Feeds matrix loads and box tests through the valid/ready input, works out
// each unpinned visible bit with an exact wide-integer plane test on a shadow
// matrix, and checks every output beat in order under several idling patterns.
// ----------------------------------------------------------------------------
module frustum_box_cull_test;
  import fbc_pkg::*;

  typedef struct packed {
    logic                 opcode;
    logic [MAT_IDX_W-1:0] index;
    logic [DATA_W-1:0]    value;
    logic [DATA_W-1:0]    cx, cy, cz;
    logic [EXT_W-1:0]     ex, ey, ez;
    logic                 bounds_ok;
    logic                 pinned;
    logic                 pin_vis;
  } cull_beat_t;

  localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] Q_NEG_TWO = 32'hFFFE_0000;
  localparam logic [DATA_W-1:0] S_MIN     = 32'h8000_0000;
  localparam logic [DATA_W-1:0] S_MAX     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] LSB_NEG   = 32'hFFFF_FFFF;
  localparam logic [EXT_W-1:0]  E_MAX     = 31'h7FFF_FFFF;
  localparam logic [EXT_W-1:0]  E_HALF    = 31'h0000_8000;
  localparam logic [EXT_W-1:0]  E_ZERO    = 31'd0;
  localparam int unsigned       HOLD_CYCLES = 400;
  localparam int unsigned       NUM_PHASES  = 4;
  localparam int unsigned       PHASE_BEATS = 310;
  localparam int unsigned       MAX_PRINTS  = 20;

  localparam cull_beat_t DIRECTED [21] = '{
    '{OP_TEST, 4'd0,  32'd0,        S_MIN, S_MIN, S_MIN, E_MAX, E_MAX, E_MAX,
      1'b1, 1'b1, 1'b1},
    '{OP_TEST, 4'd15, 32'hDEAD_BEEF, S_MAX, S_MAX, S_MAX, E_ZERO, E_ZERO, E_ZERO,
      1'b1, 1'b1, 1'b1},
    '{OP_LOAD, 4'd15, Q_NEG_ONE,    32'h1234_5678, S_MIN, S_MAX, E_MAX, 31'd7, E_MAX,
      1'b1, 1'b0, 1'b0},
    '{OP_TEST, 4'd3,  S_MIN,        32'd0, 32'd0, 32'd0, E_ZERO, E_ZERO, E_ZERO,
      1'b1, 1'b1, 1'b1},
    '{OP_LOAD, 4'd15, Q_ONE,  32'd0, 32'd0, 32'd0, E_ZERO, E_ZERO, E_ZERO, 1'b0, 1'b0, 1'b0},
    '{OP_LOAD, 4'd0,  Q_ONE,  32'd0, 32'd0, 32'd0, E_ZERO, E_ZERO, E_ZERO, 1'b0, 1'b0, 1'b0},
    '{OP_LOAD, 4'd5,  Q_ONE,  32'd0, 32'd0, 32'd0, E_ZERO, E_ZERO, E_ZERO, 1'b0, 1'b0, 1'b0},
    '{OP_LOAD, 4'd10, Q_ONE,  32'd0, 32'd0, 32'd0, E_ZERO, E_ZERO, E_ZERO, 1'b0, 1'b0, 1'b0},
    '{OP_TEST, 4'd0,  32'd0,  32'd0, 32'd0, 32'd0, E_ZERO, E_ZERO, E_ZERO, 1'b1, 1'b0, 1'b0},
    '{OP_TEST, 4'd0,  32'd0,  Q_NEG_TWO, 32'd0, 32'd0, E_HALF, E_HALF, E_HALF,
      1'b1, 1'b0, 1'b0},
    '{OP_TEST, 4'd0,  32'd0,  32'd0, 32'd0, LSB_NEG, E_ZERO, E_ZERO, E_ZERO,
      1'b1, 1'b0, 1'b0},
    '{OP_TEST, 4'd0,  32'd0,  32'd0, 32'd0, LSB_NEG, E_ZERO, E_ZERO, 31'd1,
      1'b1, 1'b0, 1'b0},
    '{OP_TEST, 4'd7,  S_MAX,  Q_NEG_TWO, Q_NEG_TWO, LSB_NEG, E_ZERO, E_ZERO, E_ZERO,
      1'b0, 1'b1, 1'b1},
    '{OP_TEST, 4'd0,  32'd0,  S_MAX, S_MIN, 32'd0, E_MAX, E_MAX, E_MAX, 1'b1, 1'b0, 1'b0},
    '{OP_LOAD, 4'd12, S_MIN,  S_MAX, S_MAX, S_MAX, E_MAX, E_MAX, E_MAX, 1'b0, 1'b0, 1'b0},
    '{OP_LOAD, 4'd0,  S_MIN,  32'd0, 32'd0, 32'd0, E_ZERO, E_ZERO, E_ZERO, 1'b1, 1'b0, 1'b0},
    '{OP_LOAD, 4'd3,  S_MAX,  32'd0, 32'd0, 32'd0, E_ZERO, E_ZERO, E_ZERO, 1'b0, 1'b0, 1'b0},
    '{OP_TEST, 4'd0,  32'd0,  S_MIN, 32'd0, 32'd0, E_ZERO, E_ZERO, E_ZERO, 1'b1, 1'b0, 1'b0},
    '{OP_TEST, 4'd0,  32'd0,  S_MAX, S_MIN, S_MAX, E_MAX, E_MAX, E_MAX, 1'b1, 1'b0, 1'b0},
    '{OP_LOAD, 4'd9,  LSB_NEG, 32'd0, 32'd0, 32'd0, E_ZERO, E_ZERO, E_ZERO, 1'b0, 1'b0, 1'b0},
    '{OP_TEST, 4'd0,  32'd0,  32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000,
      31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 1'b1, 1'b0, 1'b0}
  };

  localparam int unsigned PHASE_GAP   [NUM_PHASES] = '{0, 64, 0, 12};
  localparam int unsigned PHASE_STALL [NUM_PHASES] = '{0, 0, 64, 12};

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     opcode_i;
  logic [MAT_IDX_W-1:0]     element_index_i;
  logic signed [DATA_W-1:0] element_value_i;
  logic signed [DATA_W-1:0] center_x_i;
  logic signed [DATA_W-1:0] center_y_i;
  logic signed [DATA_W-1:0] center_z_i;
  logic [EXT_W-1:0]         extent_x_i;
  logic [EXT_W-1:0]         extent_y_i;
  logic [EXT_W-1:0]         extent_z_i;
  logic                     bounds_valid_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     visible_o;

  logic signed [DATA_W-1:0] matrix_shadow [MAT_DEPTH];
  logic                     visible_q [$];
  logic                     pin_active;
  logic                     pin_value;
  logic                     hold_req;
  logic                     hold_ack;
  int unsigned              gap_pct;
  int unsigned              stall_pct;
  int unsigned              n_errors;
  int unsigned              n_loads;
  int unsigned              n_tests;
  int unsigned              n_culled;
  int unsigned              n_shown;

  frustum_box_cull DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  // exact sign of n.c + d + |n|.e per plane, all in 128-bit two's complement
  function automatic logic predict_visible(input logic [DATA_W-1:0] cx, cy, cz,
                                           input logic [EXT_W-1:0] ex, ey, ez,
                                           input logic bounds_ok);
    logic signed [127:0] ctr [3];
    logic signed [127:0] ext [3];
    logic signed [127:0] pl [4];
    logic signed [127:0] w, row_v, mag, acc;
    int unsigned         sel_row;
    if (!bounds_ok) begin
      return 1'b1;
    end
    ctr[0] = $signed(cx);
    ctr[1] = $signed(cy);
    ctr[2] = $signed(cz);
    ext[0] = ex;
    ext[1] = ey;
    ext[2] = ez;
    for (int p = 0; p < NUM_PLANES; p++) begin
      sel_row = (p < 4) ? p / 2 : 2;
      for (int k = 0; k < MAT_COLS; k++) begin
        w     = matrix_shadow[12 + k];
        row_v = matrix_shadow[sel_row * MAT_COLS + k];
        if (p == 4) begin
          pl[k] = row_v;
        end else if (p % 2 == 0) begin
          pl[k] = w + row_v;
        end else begin
          pl[k] = w - row_v;
        end
      end
      if (pl[0] == 0 && pl[1] == 0 && pl[2] == 0) begin
        continue;
      end
      acc = pl[3] <<< FRAC_W;
      for (int a = 0; a < NUM_AXES; a++) begin
        mag = (pl[a] < 0) ? -pl[a] : pl[a];
        acc = acc + pl[a] * ctr[a] + mag * ext[a];
      end
      if (acc < 0) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (opcode_i == OP_LOAD) begin
        matrix_shadow[element_index_i] = element_value_i;
        n_loads++;
      end else begin
        visible_q.push_back(pin_active ? pin_value :
                            predict_visible(center_x_i, center_y_i, center_z_i,
                                            extent_x_i, extent_y_i, extent_z_i,
                                            bounds_valid_i));
        n_tests++;
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (visible_q.size() == 0) begin
        report_mismatch("output beat with no box test outstanding");
      end else begin
        want = visible_q.pop_front();
        if (visible_o !== want) begin
          report_mismatch($sformatf("visible %b, predicted %b", visible_o, want));
        end
        if (visible_o === 1'b0) begin
          n_culled++;
        end else begin
          n_shown++;
        end
      end
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    hold_ack    = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_beat(input cull_beat_t b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    opcode_i        = b.opcode;
    element_index_i = b.index;
    element_value_i = b.value;
    center_x_i      = b.cx;
    center_y_i      = b.cy;
    center_z_i      = b.cz;
    extent_x_i      = b.ex;
    extent_y_i      = b.ey;
    extent_z_i      = b.ez;
    bounds_valid_i  = b.bounds_ok;
    pin_active      = b.pinned;
    pin_value       = b.pin_vis;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (visible_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_coord(input int unsigned span);
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [EXT_W-1:0] pick_extent();
    if ($urandom_range(3) == 0) begin
      return EXT_W'($urandom);
    end
    return EXT_W'($urandom_range(0, 32'h0002_0000));
  endfunction

  function automatic cull_beat_t random_load(input int unsigned idx);
    cull_beat_t b;
    b           = '0;
    b.opcode    = OP_LOAD;
    b.index     = MAT_IDX_W'(idx);
    b.value     = ($urandom_range(9) < 7) ? pick_coord(32'h0004_0000) : $urandom;
    b.cx        = $urandom;
    b.cy        = $urandom;
    b.cz        = $urandom;
    b.ex        = EXT_W'($urandom);
    b.ey        = EXT_W'($urandom);
    b.ez        = EXT_W'($urandom);
    b.bounds_ok = 1'($urandom_range(1));
    b.pinned    = 1'b0;
    return b;
  endfunction

  function automatic cull_beat_t random_test();
    cull_beat_t b;
    b           = '0;
    b.opcode    = OP_TEST;
    b.index     = MAT_IDX_W'($urandom);
    b.value     = $urandom;
    b.cx        = pick_coord(32'h0008_0000);
    b.cy        = pick_coord(32'h0008_0000);
    b.cz        = pick_coord(32'h0008_0000);
    b.ex        = pick_extent();
    b.ey        = pick_extent();
    b.ez        = pick_extent();
    b.bounds_ok = ($urandom_range(9) != 0);
    b.pinned    = 1'b0;
    return b;
  endfunction

  task automatic run_random(input int unsigned beats);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(5) == 0) begin
        for (int i = 0; i < MAT_DEPTH; i++) begin
          send_beat(random_load(i));
        end
        sent += MAT_DEPTH;
      end else if ($urandom_range(9) == 0) begin
        send_beat(random_load($urandom_range(MAT_DEPTH - 1)));
        sent++;
      end else begin
        burst = $urandom_range(4, 12);
        repeat (burst) send_beat(random_test());
        sent += burst;
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    opcode_i        = OP_LOAD;
    element_index_i = '0;
    element_value_i = '0;
    center_x_i      = '0;
    center_y_i      = '0;
    center_z_i      = '0;
    extent_x_i      = '0;
    extent_y_i      = '0;
    extent_z_i      = '0;
    bounds_valid_i  = 1'b0;
    pin_active      = 1'b0;
    pin_value       = 1'b0;
    hold_req        = 1'b0;
    gap_pct         = 0;
    stall_pct       = 0;
    n_errors        = 0;
    n_loads         = 0;
    n_tests         = 0;
    n_culled        = 0;
    n_shown         = 0;
    foreach (matrix_shadow[i]) matrix_shadow[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) send_beat(DIRECTED[i]);

    // hold the output off while box tests keep arriving back to back
    hold_req = ~hold_req;
    repeat (40) send_beat(random_test());
    wait_results_drained();
    @(negedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gap_pct   = PHASE_GAP[ph];
      stall_pct = PHASE_STALL[ph];
      run_random(PHASE_BEATS);
      wait_results_drained();
    end

    in_valid_i = 1'b0;
    while (visible_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (60) @(posedge clk_i);

    $display("Covered %0d matrix loads and %0d box tests (%0d culled, %0d visible)",
             n_loads, n_tests, n_culled, n_shown);
    $display("Idling: none, sender gaps, receiver stalls, both; one long output hold-off");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### frustum_box_cull.f
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_front.sv
hw/rtl/fbc_queue.sv
hw/rtl/fbc_back.sv
hw/rtl/frustum_box_cull.sv
bench/frustum_box_cull_test.sv
